FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/sssa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sssa_pkg
// Shared types, register indexes and constants of the seek steering step.
// ----------------------------------------------------------------------------
package sssa_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_MAX_SPEED = 8'd0;
    localparam logic [7:0] CFG_MAX_FORCE = 8'd1;
    localparam logic [7:0] CFG_START_X   = 8'd2;
    localparam logic [7:0] CFG_START_Y   = 8'd3;

    // angles in 2^-16 degree, heading wrap in 2^-7 degree
    localparam logic signed [26:0] DEG180 = 27'sd11796480;
    localparam logic signed [26:0] DEG360 = 27'sd23592960;
    localparam logic [15:0] HEADING_WRAP  = 16'd46080;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic load;
        logic sqx;
        logic sqy;
        logic sqrt_go;
        logic mulx;
        logic muly;
        logic div_go;
        logic wrx;
        logic wry;
        logic force_f;
        logic fcopy;
        logic sum;
        logic move;
        logic out_wr;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic cord_busy;
        logic clip;
        logic out_hold;
    } t_stat;

    // arctangent of 2^-i in 2^-16 degree
    function automatic logic [21:0] atan_deg16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/seek_steering_agent_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seek_steering_agent_step
// Seek steering agent: one frame tick per transaction, new position and
// heading per tick.
//
//   channel | dir | signals                          | content
//   s_axis  | in  | i_s_tvalid o_s_tready tdata tuser| target, restart flag
//   m_axis  | out | o_m_tvalid i_m_tready tdata      | position, heading
//   cfg     | in  | i_cfg_valid o_cfg_ready addr data| register writes
//
// In a tick, two or three 32-step square roots (three when the force is
// clipped), four or six 17-step divisions and the CORDIC rotations run
// one after another; the next tick is accepted once the result is written.
// A new transaction is taken while the previous result waits in the output
// register; the result write stalls until that register is free.
// Reset is synchronous; it clears agent state and loads register defaults.
// ----------------------------------------------------------------------------
module seek_steering_agent_step
    import sssa_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // target_x[31:0], target_y[63:32]
    input  wire         i_s_tuser,   // restart
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [79:0] o_m_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_data
);

    localparam logic [63:0] SPD_RST64 = ((64'd13107 << FRAC_BITS) + 64'd131072) >> 18;
    localparam logic [63:0] FRC_RST64 = ((64'd786 << FRAC_BITS) + 64'd131072) >> 18;

    logic [16:0] r_spd, r_frc;
    logic [31:0] r_stx, r_sty;
    t_cmd        w_cmd;
    t_stat       w_st;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd <= SPD_RST64[16:0];
            r_frc <= FRC_RST64[16:0];
            r_stx <= '0;
            r_sty <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_MAX_SPEED: r_spd <= i_cfg_data[16:0];
                CFG_MAX_FORCE: r_frc <= i_cfg_data[16:0];
                CFG_START_X:   r_stx <= i_cfg_data;
                CFG_START_Y:   r_sty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    sssa_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_spd      (r_spd),
        .i_frc      (r_frc),
        .i_start_x  (r_stx),
        .i_start_y  (r_sty),
        .i_restart  (i_s_tuser),
        .i_target_x (i_s_tdata[31:0]),
        .i_target_y (i_s_tdata[63:32]),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata)
    );

endmodule
`default_nettype wire

FILE: rtl/core/sssa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sssa_ctrl
// Sequencer: walks two or three vector rescales, CORDIC and result write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sssa_ctrl
    import sssa_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOAD  = 5'd1;
    localparam logic [4:0] S_SQX   = 5'd2;
    localparam logic [4:0] S_SQY   = 5'd3;
    localparam logic [4:0] S_CMP   = 5'd4;
    localparam logic [4:0] S_SQRT  = 5'd5;
    localparam logic [4:0] S_SQW   = 5'd6;
    localparam logic [4:0] S_MULX  = 5'd7;
    localparam logic [4:0] S_DX    = 5'd8;
    localparam logic [4:0] S_DXW   = 5'd9;
    localparam logic [4:0] S_MULY  = 5'd10;
    localparam logic [4:0] S_DY    = 5'd11;
    localparam logic [4:0] S_DYW   = 5'd12;
    localparam logic [4:0] S_FORCE = 5'd13;
    localparam logic [4:0] S_FCOPY = 5'd14;
    localparam logic [4:0] S_SUM   = 5'd15;
    localparam logic [4:0] S_MOVE  = 5'd16;
    localparam logic [4:0] S_CW    = 5'd17;
    localparam logic [4:0] S_OUTW  = 5'd18;

    localparam logic [1:0] PH_TGT = 2'd0;
    localparam logic [1:0] PH_FRC = 2'd1;
    localparam logic [1:0] PH_VEL = 2'd2;

    logic [4:0] r_state, n_state;
    logic [1:0] r_ph, n_ph;
    logic       w_start;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_start    = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_ph    = PH_TGT;
                n_state = S_SQX;
            end
            S_SQX: begin
                o_cmd.sqx = 1'b1;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_cmd.sqy = 1'b1;
                n_state = (r_ph == PH_FRC) ? S_CMP : S_SQRT;
            end
            S_CMP: begin
                n_state = i_st.clip ? S_SQRT : S_SUM;
            end
            S_SQRT: begin
                o_cmd.sqrt_go = 1'b1;
                n_state = S_SQW;
            end
            S_SQW: begin
                if (!i_st.sqrt_busy) n_state = S_MULX;
            end
            S_MULX: begin
                o_cmd.mulx = 1'b1;
                n_state = S_DX;
            end
            S_DX: begin
                o_cmd.div_go = 1'b1;
                n_state = S_DXW;
            end
            S_DXW: begin
                if (!i_st.div_busy) begin
                    o_cmd.wrx = 1'b1;
                    n_state = S_MULY;
                end
            end
            S_MULY: begin
                o_cmd.muly = 1'b1;
                n_state = S_DY;
            end
            S_DY: begin
                o_cmd.div_go = 1'b1;
                n_state = S_DYW;
            end
            S_DYW: begin
                if (!i_st.div_busy) begin
                    o_cmd.wry = 1'b1;
                    case (r_ph)
                        PH_TGT:  n_state = S_FORCE;
                        PH_FRC:  n_state = S_FCOPY;
                        default: n_state = S_MOVE;
                    endcase
                end
            end
            S_FORCE: begin
                o_cmd.force_f = 1'b1;
                n_ph    = PH_FRC;
                n_state = S_SQX;
            end
            S_FCOPY: begin
                o_cmd.fcopy = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_ph    = PH_VEL;
                n_state = S_SQX;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = S_CW;
            end
            S_CW: begin
                if (!i_st.cord_busy) n_state = S_OUTW;
            end
            S_OUTW: begin
                if (!i_st.out_hold) begin
                    o_cmd.out_wr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_TGT;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    `AST_NEXT(a_start_load, i_clk, i_rst_n, w_start, r_state == S_LOAD)
    `AST_IMPL(a_out_free, i_clk, i_rst_n, o_cmd.out_wr, !i_st.out_hold)
    `AST_NEXT(a_div_wait, i_clk, i_rst_n, (r_state == S_DXW) && i_st.div_busy, r_state == S_DXW)

endmodule
`default_nettype wire

FILE: rtl/core/sssa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sssa_dp
// Datapath: agent state, shared squarer/multiplier, iterative square root,
// divider and CORDIC, and the result register.
// ----------------------------------------------------------------------------
module sssa_dp
    import sssa_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_st,
    input  wire  [16:0] i_spd,
    input  wire  [16:0] i_frc,
    input  wire  [31:0] i_start_x,
    input  wire  [31:0] i_start_y,
    input  wire         i_restart,
    input  wire  [31:0] i_target_x,
    input  wire  [31:0] i_target_y,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [79:0] o_data
);

    localparam int CCW = $clog2(CORDIC_STEPS + 1);
    localparam int CXW = 42;

    // agent state
    logic [31:0]        r_px, r_py;
    logic signed [17:0] r_vx, r_vy;
    // latched input
    logic [31:0]        r_tx, r_ty;
    logic               r_rst;
    // working vector
    logic [31:0]        r_ax, r_ay;
    logic               r_nx, r_ny;
    logic [16:0]        r_k;
    logic [63:0]        r_sq;
    logic signed [18:0] r_wx, r_wy, r_fx, r_fy;
    logic [48:0]        r_dvd;
    // square root unit
    logic [63:0]        r_rad;
    logic [33:0]        r_srem;
    logic [31:0]        r_root;
    logic [5:0]         r_scnt;
    // divider
    logic [31:0]        r_drem;
    logic [16:0]        r_dq;
    logic [4:0]         r_dcnt;
    // CORDIC
    logic signed [CXW-1:0] r_cx, r_cy;
    logic signed [26:0]    r_cz;
    logic [CCW-1:0]        r_ccnt;
    logic [4:0]            r_ci;
    logic                  r_vz;
    // result
    logic                  r_ovalid;
    logic [79:0]           r_odata;

    // restart and target offset
    logic [31:0]        w_pxe, w_pye;
    logic [32:0]        w_dx, w_dy, w_adx, w_ady;
    logic               w_half;
    always_comb begin
        w_pxe  = r_rst ? i_start_x : r_px;
        w_pye  = r_rst ? i_start_y : r_py;
        w_dx   = {r_tx[31], r_tx} - {w_pxe[31], w_pxe};
        w_dy   = {r_ty[31], r_ty} - {w_pye[31], w_pye};
        w_adx  = w_dx[32] ? (33'd0 - w_dx) : w_dx;
        w_ady  = w_dy[32] ? (33'd0 - w_dy) : w_dy;
        w_half = w_adx[32] || w_adx[31] || w_ady[32] || w_ady[31];
    end

    // shared squarer and scaler
    logic [31:0] w_sqin, w_mulin;
    logic [63:0] w_sqp;
    logic [48:0] w_mulp;
    assign w_sqin  = i_cmd.sqy ? r_ay : r_ax;
    assign w_sqp   = w_sqin * w_sqin;
    assign w_mulin = i_cmd.muly ? r_ay : r_ax;
    assign w_mulp  = {17'd0, w_mulin} * {32'd0, r_k};

    // force and sum vectors
    logic signed [18:0] w_fx, w_fy, w_sx, w_sy;
    assign w_fx = r_wx - {r_vx[17], r_vx};
    assign w_fy = r_wy - {r_vy[17], r_vy};
    assign w_sx = {r_vx[17], r_vx} + r_fx;
    assign w_sy = {r_vy[17], r_vy} + r_fy;

    // divider result with sign
    logic [16:0]        w_mag;
    logic signed [18:0] w_res;
    always_comb begin
        w_mag = (r_root == 32'd0) ? 17'd0 : r_dq;
        if (i_cmd.wry) w_res = r_ny ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
        else           w_res = r_nx ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
    end

    // square root step
    logic [35:0] w_srt, w_strial;
    assign w_srt    = {r_srem, r_rad[63:62]};
    assign w_strial = {2'b00, r_root, 2'b01};

    // divider step
    logic [32:0] w_drt;
    assign w_drt = {r_drem, r_dq[16]};

    // CORDIC init and step
    logic signed [CXW-1:0] w_ix, w_iy, w_shx, w_shy;
    logic signed [26:0]    w_at;
    assign w_ix  = {{(CXW-19){r_wx[18]}}, r_wx} <<< 20;
    assign w_iy  = {{(CXW-19){r_wy[18]}}, r_wy} <<< 20;
    assign w_shx = r_cx >>> r_ci;
    assign w_shy = r_cy >>> r_ci;
    assign w_at  = $signed({5'd0, atan_deg16(r_ci)});

    // heading from final angle
    logic signed [26:0] w_zw;
    logic [26:0]        w_zr;
    logic [15:0]        w_hd;
    always_comb begin
        w_zw = r_cz[26] ? (r_cz + DEG360) : r_cz;
        w_zr = $unsigned(w_zw) + 27'd256;
        w_hd = w_zr[24:9];
        if (r_vz || (w_hd == HEADING_WRAP)) w_hd = 16'd0;
    end

    logic [31:0] w_npx, w_npy;
    assign w_npx = r_px + {{13{r_wx[18]}}, r_wx};
    assign w_npy = r_py + {{13{r_wy[18]}}, r_wy};

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tx  <= i_target_x;
            r_ty  <= i_target_y;
            r_rst <= i_restart;
        end
        if (i_cmd.load) begin
            r_ax <= w_half ? w_adx[32:1] : w_adx[31:0];
            r_ay <= w_half ? w_ady[32:1] : w_ady[31:0];
            r_nx <= w_dx[32];
            r_ny <= w_dy[32];
            r_k  <= i_spd;
        end
        if (i_cmd.sqx) r_sq <= w_sqp;
        if (i_cmd.sqy) r_sq <= r_sq + w_sqp;
        if (i_cmd.mulx || i_cmd.muly) r_dvd <= w_mulp;
        if (i_cmd.wrx) r_wx <= w_res;
        if (i_cmd.wry) r_wy <= w_res;
        if (i_cmd.force_f) begin
            r_fx <= w_fx;
            r_fy <= w_fy;
            r_ax <= {13'd0, (w_fx[18] ? -w_fx : w_fx)};
            r_ay <= {13'd0, (w_fy[18] ? -w_fy : w_fy)};
            r_nx <= w_fx[18];
            r_ny <= w_fy[18];
            r_k  <= i_frc;
        end
        if (i_cmd.fcopy) begin
            r_fx <= r_wx;
            r_fy <= r_wy;
        end
        if (i_cmd.sum) begin
            r_ax <= {13'd0, (w_sx[18] ? -w_sx : w_sx)};
            r_ay <= {13'd0, (w_sy[18] ? -w_sy : w_sy)};
            r_nx <= w_sx[18];
            r_ny <= w_sy[18];
            r_k  <= i_spd;
        end
    end

    // agent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_vx <= '0;
            r_vy <= '0;
        end else if (i_cmd.load) begin
            r_px <= w_pxe;
            r_py <= w_pye;
            if (r_rst) begin
                r_vx <= '0;
                r_vy <= '0;
            end
        end else if (i_cmd.move) begin
            r_px <= w_npx;
            r_py <= w_npy;
            r_vx <= r_wx[17:0];
            r_vy <= r_wy[17:0];
        end
    end

    // square root: two radicand bits per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
        end else if (i_cmd.sqrt_go) begin
            r_rad  <= r_sq;
            r_srem <= '0;
            r_root <= '0;
            r_scnt <= 6'd32;
        end else if (r_scnt != 6'd0) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_scnt <= r_scnt - 6'd1;
            if (w_srt >= w_strial) begin
                r_srem <= 34'(w_srt - w_strial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_srem <= w_srt[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    // divider: one quotient bit per cycle, quotient below 2^17
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_go) begin
            r_drem <= r_dvd[48:17];
            r_dq   <= r_dvd[16:0];
            r_dcnt <= 5'd17;
        end else if (r_dcnt != 5'd0) begin
            r_dcnt <= r_dcnt - 5'd1;
            if (w_drt >= {1'b0, r_root}) begin
                r_drem <= 32'(w_drt - {1'b0, r_root});
                r_dq   <= {r_dq[15:0], 1'b1};
            end else begin
                r_drem <= w_drt[31:0];
                r_dq   <= {r_dq[15:0], 1'b0};
            end
        end
    end

    // CORDIC vectoring, one micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
        end else if (i_cmd.move) begin
            r_vz   <= (r_wx == 19'sd0) && (r_wy == 19'sd0);
            r_ci   <= '0;
            r_ccnt <= CCW'(CORDIC_STEPS);
            if (r_wx[18]) begin
                r_cx <= -w_ix;
                r_cy <= -w_iy;
                r_cz <= DEG180;
            end else begin
                r_cx <= w_ix;
                r_cy <= w_iy;
                r_cz <= '0;
            end
        end else if (r_ccnt != '0) begin
            r_ccnt <= r_ccnt - 1'b1;
            r_ci   <= r_ci + 5'd1;
            if (r_cy > 0) begin
                r_cx <= r_cx + w_shy;
                r_cy <= r_cy - w_shx;
                r_cz <= r_cz + w_at;
            end else begin
                r_cx <= r_cx - w_shy;
                r_cy <= r_cy + w_shx;
                r_cz <= r_cz - w_at;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) r_odata <= {w_hd, r_py, r_px};
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    assign o_st.sqrt_busy = (r_scnt != 6'd0);
    assign o_st.div_busy  = (r_dcnt != 5'd0);
    assign o_st.cord_busy = (r_ccnt != '0);
    assign o_st.clip      = r_sq > {30'd0, ({17'd0, i_frc} * {17'd0, i_frc})};
    assign o_st.out_hold  = r_ovalid && !i_ready;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seek steering step. Ticks go in on the slave
// stream and the bench predicts position and heading for each one. Every
// result on the master stream is checked against the oldest prediction.
// Phases change the register settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import sssa_pkg::*;

    localparam int  PHASES       = 8;
    localparam int  RAND_ITEMS   = 210;
    localparam int  DRAIN_CYCLES = 400;
    localparam logic [7:0] CFG_UNMAPPED = 8'd200;

    // Predicts the agent and checks the results in order
    class steer_scoreboard;
        localparam int           STEPS     = 16;
        localparam longint       ANG360    = 64'sd23592960;
        localparam longint       ANG180    = 64'sd11796480;
        localparam longint       HDG_LIMIT = 64'sd46080;

        longint unsigned speed_lim, force_lim;
        logic [31:0]     home_x, home_y;
        logic [31:0]     pos_x, pos_y, vel_x, vel_y;
        logic [79:0]     expected_q[$];
        int              n_checked, n_bad;

        function new();
            speed_lim = 3277;
            force_lim = 197;
            home_x = '0; home_y = '0;
            pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
            n_checked = 0; n_bad = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] val);
            case (idx)
                CFG_MAX_SPEED: speed_lim = val[16:0];
                CFG_MAX_FORCE: force_lim = val[16:0];
                CFG_START_X:   home_x = val;
                CFG_START_Y:   home_y = val;
                default: ;
            endcase
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // signed component scaled to length k of a vector of length len
        function longint scale_to(longint c, longint unsigned amag,
                                  longint unsigned k, longint unsigned len);
            longint unsigned m;
            if (len == 0) return 0;
            m = amag * k / len;
            return (c < 0) ? -longint'(m) : longint'(m);
        endfunction

        // CORDIC vectoring angle, 1/128 degree
        function logic [15:0] heading_of(longint vx, longint vy);
            longint arc[STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
                                   117304, 58666, 29335, 14668, 7334, 3667,
                                   1833, 917, 458, 229, 115};
            longint x, y, z, xn, h;
            if (vx == 0 && vy == 0) return '0;
            x = vx * 1048576;
            y = vy * 1048576;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = ANG180;
            end
            for (int i = 0; i < STEPS; i++) begin
                if (y > 0) begin
                    xn = x + (y >>> i);
                    y  = y - (x >>> i);
                    z += arc[i];
                end else begin
                    xn = x - (y >>> i);
                    y  = y + (x >>> i);
                    z -= arc[i];
                end
                x = xn;
            end
            while (z < 0) z += ANG360;
            while (z >= ANG360) z -= ANG360;
            h = (z + 256) >>> 9;
            if (h >= HDG_LIMIT) h -= HDG_LIMIT;
            return h[15:0];
        endfunction

        // one tick of the agent for an accepted input transaction
        function void note_tick(bit restart, logic [31:0] tx, logic [31:0] ty);
            longint px, py, vx, vy, dx, dy, wx, wy, fx, fy, sx, sy;
            longint unsigned ax, ay, len, fm2;
            if (restart) begin
                pos_x = home_x; pos_y = home_y;
                vel_x = '0; vel_y = '0;
            end
            px = $signed(pos_x); py = $signed(pos_y);
            vx = $signed(vel_x); vy = $signed(vel_y);
            dx = longint'($signed(tx)) - px;
            dy = longint'($signed(ty)) - py;
            ax = mag(dx); ay = mag(dy);
            if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
                ax >>= 1; ay >>= 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            wx = scale_to(dx, ax, speed_lim, len);
            wy = scale_to(dy, ay, speed_lim, len);
            // steering force, clipped to the force limit
            fx = wx - vx; fy = wy - vy;
            fm2 = mag(fx) * mag(fx) + mag(fy) * mag(fy);
            if (fm2 > force_lim * force_lim) begin
                len = int_sqrt(fm2);
                fx = scale_to(fx, mag(fx), force_lim, len);
                fy = scale_to(fy, mag(fy), force_lim, len);
            end
            sx = vx + fx; sy = vy + fy;
            len = int_sqrt(mag(sx) * mag(sx) + mag(sy) * mag(sy));
            vx = scale_to(sx, mag(sx), speed_lim, len);
            vy = scale_to(sy, mag(sy), speed_lim, len);
            vel_x = vx[31:0]; vel_y = vy[31:0];
            pos_x = pos_x + vx[31:0];
            pos_y = pos_y + vy[31:0];
            expected_q.push_back({heading_of(vx, vy), pos_y, pos_x});
        endfunction

        function void check_result(logic [79:0] got);
            logic [79:0] want;
            if (expected_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("[%0t] unexpected result %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got[31:0] !== want[31:0] || got[63:32] !== want[63:32] ||
                got[79:64] !== want[79:64]) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("[%0t] mismatch pos_x %h/%h pos_y %h/%h heading %0d/%0d",
                             $time, want[31:0], got[31:0], want[63:32], got[63:32],
                             want[79:64], got[79:64]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    wire         o_s_tready, o_m_tvalid, o_cfg_ready;
    wire  [79:0] o_m_tdata;

    steer_scoreboard agent_sb = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          ticks_sent = 0;
    int          restarts_sent = 0;

    seek_steering_agent_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result check on each accepted output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            agent_sb.check_result(o_m_tdata);
    end

    task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        agent_sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one tick; tvalid stays high when the next one follows without a gap
    task automatic send_tick(bit restart, logic [31:0] tx, logic [31:0] ty);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ty, tx};
        i_s_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        agent_sb.note_tick(restart, tx, ty);
        ticks_sent++;
        if (restart) restarts_sent++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (agent_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random tick: mostly seeking near the agent, some far or exact targets
    task automatic random_tick();
        logic [31:0] tx, ty;
        int          pick, span;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 31);
        if (pick < 70) begin
            tx = agent_sb.pos_x + ($urandom() >>> (31 - span)) - (32'd1 << span);
            ty = agent_sb.pos_y + ($urandom() >>> (31 - span)) - (32'd1 << span);
        end else if (pick < 90) begin
            tx = $urandom();
            ty = $urandom();
        end else begin
            tx = agent_sb.pos_x;
            ty = agent_sb.pos_y;
        end
        send_tick($urandom_range(0, 9) == 0, tx, ty);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks under reset settings
        send_tick(1'b0, 32'h0, 32'h0);              // target on the agent
        send_tick(1'b0, 32'h7FFF_FFFF, 32'h0);
        send_tick(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_tick(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tick(1'b1, 32'hFFFF_0000, 32'h0001_0000);
        send_tick(1'b0, 32'hFFFF_0000, 32'hFFFF_0000);
        send_tick(1'b0, 32'h0001_0000, 32'hFFFF_0000);
        send_tick(1'b1, 32'h0, 32'h0);              // restart onto the target
        send_tick(1'b0, 32'h0, 32'h0);
        wait_idle();
        cfg_write(CFG_START_X, 32'h7FFF_FFF0);
        cfg_write(CFG_START_Y, 32'h8000_0000);
        cfg_write(CFG_MAX_SPEED, 32'hFFF1_0000);    // upper bits dropped
        cfg_write(CFG_MAX_FORCE, 32'd65536);
        cfg_write(CFG_UNMAPPED, 32'h0000_0005);     // ignored write
        send_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++)                 // position wraps
            send_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_tick(1'b1, 32'h0, 32'h0);
        send_tick(1'b0, 32'h7FFF_FFF0, 32'h8000_0000);
        wait_idle();

        // random phases with different settings and flow control
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            case (ph)
                0: begin cfg_write(CFG_MAX_SPEED, 32'd3277); cfg_write(CFG_MAX_FORCE, 32'd197); end
                1: begin cfg_write(CFG_MAX_SPEED, 32'd0);    cfg_write(CFG_MAX_FORCE, 32'd197); end
                2: begin cfg_write(CFG_MAX_SPEED, 32'd3277); cfg_write(CFG_MAX_FORCE, 32'd0);   end
                3: begin cfg_write(CFG_MAX_SPEED, 32'd65536); cfg_write(CFG_MAX_FORCE, 32'd1);  end
                default: begin
                    cfg_write(CFG_MAX_SPEED, $urandom_range(0, 65536));
                    cfg_write(CFG_MAX_FORCE, $urandom_range(0, 65536));
                end
            endcase
            cfg_write(CFG_START_X, $urandom());
            cfg_write(CFG_START_Y, $urandom());
            for (int i = 0; i < RAND_ITEMS; i++) random_tick();
            wait_idle();
        end

        $display("Sent %0d ticks (%0d restarts), checked %0d results over %0d phases.",
                 ticks_sent, restarts_sent, agent_sb.n_checked, PHASES);
        $display("Covered speed/force extremes, wrapping positions and flow-control mixes.");
        if (agent_sb.n_bad == 0 && agent_sb.expected_q.size() == 0) begin
            $display("** seek_steering_agent_step: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     agent_sb.n_bad, agent_sb.expected_q.size());
            $display("** seek_steering_agent_step: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #100ms;
        $display("timeout with %0d results outstanding", agent_sb.expected_q.size());
        $display("** seek_steering_agent_step: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sssa_pkg.sv
rtl/core/sssa_ctrl.sv
rtl/core/sssa_dp.sv
rtl/core/seek_steering_agent_step.sv
sim/tb_top.sv
